>>> rtl/core/dsr_pkg.sv
// shared types, constants and compact-target helpers for the retarget block
package dsr_pkg;

  localparam int TARGET_BITS = 256;
  localparam int DIV_W       = 32;   // divisor width
  localparam int Q_W         = 65;   // quotient bits kept
  localparam int D_W         = 96;   // dividend width, Q_W + DIV_W - 1
  localparam int SH_W        = 9;    // holds a shift up to TARGET_BITS

  localparam logic [1:0] HIST_NONE = 2'd0;
  localparam logic [1:0] HIST_LAST = 2'd1;

  localparam logic [1:0] CFG_DESIRED = 2'd0;
  localparam logic [1:0] CFG_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_STEPS   = 2'd2;

  // decoded compact word: value is mant << sh, or all ones when sat
  typedef struct packed {
    logic            zero;
    logic            sat;
    logic [22:0]     mant;
    logic [SH_W-1:0] sh;
  } dec_t;

  // per-item side information that rides along the divider
  typedef struct packed {
    logic            byp;
    logic [31:0]     byp_val;
    logic [SH_W-1:0] j;
  } sb_t;

  // bit length of a value (index of the top one plus one)
  function automatic logic [6:0] len65(input logic [Q_W-1:0] x);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < Q_W; i++) begin
      if (x[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  function automatic dec_t decode(input logic [31:0] bits);
    logic [7:0]  size;
    logic [22:0] m;
    logic [6:0]  lm;
    logic [10:0] ps;
    dec_t        r;
    size = bits[31:24];
    m    = bits[22:0];
    r    = '0;
    lm   = len65(Q_W'(m));
    ps   = 11'({3'b000, size} - 11'd3) << 3;
    if (bits[23]) begin
      r.zero = 1'b1;
    end else if (size <= 8'd3) begin
      r.mant = m >> {(2'd3 - size[1:0]), 3'b000};
      r.zero = (r.mant == '0);
    end else if (m == '0) begin
      r.zero = 1'b1;
    end else if (({4'b0000, lm} + ps) > 11'(TARGET_BITS)) begin
      r.sat = 1'b1;
      r.sh  = SH_W'(TARGET_BITS);
    end else begin
      r.mant = m;
      r.sh   = ps[SH_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/dsr_div.sv
// pipelined radix-2 restoring divider, one quotient bit per stage
module dsr_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_v,
  input  logic [dsr_pkg::D_W-1:0] in_d,
  input  dsr_pkg::sb_t            in_sb,
  input  logic [dsr_pkg::DIV_W-1:0] divisor,
  output logic                    out_v,
  output logic [dsr_pkg::Q_W-1:0] out_q,
  output dsr_pkg::sb_t            out_sb
);

  logic [dsr_pkg::DIV_W-1:0] rem_r [dsr_pkg::Q_W];
  logic [dsr_pkg::Q_W-1:0]   dq_r  [dsr_pkg::Q_W];
  dsr_pkg::sb_t              sb_r  [dsr_pkg::Q_W];
  logic [dsr_pkg::Q_W-1:0]   v_r;

  logic [dsr_pkg::DIV_W-1:0] rem_in [dsr_pkg::Q_W];
  logic [dsr_pkg::Q_W-1:0]   dq_in  [dsr_pkg::Q_W];
  dsr_pkg::sb_t              sb_in  [dsr_pkg::Q_W];
  logic [dsr_pkg::Q_W-1:0]   v_in;

  // top dividend bits are below the divisor, so the first remainder is exact
  assign rem_in[0] = {1'b0, in_d[dsr_pkg::D_W-1:dsr_pkg::Q_W]};
  assign dq_in[0]  = in_d[dsr_pkg::Q_W-1:0];
  assign sb_in[0]  = in_sb;
  assign v_in[0]   = in_v;

  for (genvar g = 0; g < dsr_pkg::Q_W; g++) begin : g_stage
    logic [dsr_pkg::DIV_W:0]   r2;
    logic [dsr_pkg::DIV_W:0]   sub;
    logic                      ge;
    logic [dsr_pkg::DIV_W-1:0] rem_nxt;
    logic [dsr_pkg::Q_W-1:0]   dq_nxt;

    if (g > 0) begin : g_link
      assign rem_in[g] = rem_r[g-1];
      assign dq_in[g]  = dq_r[g-1];
      assign sb_in[g]  = sb_r[g-1];
      assign v_in[g]   = v_r[g-1];
    end

    always_comb begin
      r2      = {rem_in[g], dq_in[g][dsr_pkg::Q_W-1]};
      sub     = r2 - {1'b0, divisor};
      ge      = (r2 >= {1'b0, divisor});
      rem_nxt = ge ? sub[dsr_pkg::DIV_W-1:0] : r2[dsr_pkg::DIV_W-1:0];
      dq_nxt  = {dq_in[g][dsr_pkg::Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_in[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt;
        dq_r[g]  <= dq_nxt;
        sb_r[g]  <= sb_in[g];
      end
    end
  end

  assign out_v  = v_r[dsr_pkg::Q_W-1];
  assign out_q  = dq_r[dsr_pkg::Q_W-1];
  assign out_sb = sb_r[dsr_pkg::Q_W-1];

endmodule

>>> rtl/core/digishield_target_retarget.sv
// difficulty retarget: span damping, compact decode, scale by span/desired, cap, encode; bypass on short history
//
// channel  direction  handshake             payload
// in_      input      in_valid / in_ready   history, last_time, prev_time, last_bits
// out_     output     out_valid / out_ready next_bits
// cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// one item per cycle unless the output stalls; the pipe is four front stages, the 65-stage divider,
// then normalize and cap/encode stages
// the whole pipe advances together whenever the output register is free or taken
// reset clears all valid bits and loads the register defaults
module digishield_target_retarget (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_history,
  input  logic [31:0] in_last_time,
  input  logic [31:0] in_prev_time,
  input  logic [31:0] in_last_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_next_bits,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] desired_span_r;
  logic [31:0] target_limit_r;
  logic        limit_steps_on_r;
  logic [31:0] deff;
  logic        en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desired_span_r   <= 32'd60;
      target_limit_r   <= 32'h1e0fffff;
      limit_steps_on_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsr_pkg::CFG_DESIRED: desired_span_r   <= cfg_wdata;
        dsr_pkg::CFG_LIMIT:   target_limit_r   <= cfg_wdata;
        dsr_pkg::CFG_STEPS:   limit_steps_on_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // zero desired span acts as one
  assign deff = (desired_span_r == '0) ? 32'd1 : desired_span_r;

  logic out_valid_r;
  logic [31:0] out_next_bits_r;
  logic out_byp_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage 1: raw span and decode of the last target
  logic          v1_r;
  logic [33:0]   diff1_r;
  dsr_pkg::dec_t dec1_r;
  logic          byp1_r;
  logic [31:0]   bval1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff1_r <= {2'b00, in_last_time} - {2'b00, in_prev_time};
      dec1_r  <= dsr_pkg::decode(in_last_bits);
      byp1_r  <= (in_history == dsr_pkg::HIST_NONE) || (in_history == dsr_pkg::HIST_LAST);
      bval1_r <= (in_history == dsr_pkg::HIST_NONE) ? target_limit_r : in_last_bits;
    end
  end

  // stage 2: damping and clamping
  logic signed [35:0] ds, dif, x, xs, xq, sd, lo, hi, sp;
  logic [33:0] trip;
  logic [32:0] span2_nxt;

  always_comb begin
    ds   = $signed({4'b0000, deff});
    dif  = $signed({{2{diff1_r[33]}}, diff1_r});
    trip = {2'b00, deff} + {1'b0, deff, 1'b0};
    lo   = $signed({2'b00, trip >> 2});
    hi   = $signed({2'b00, trip >> 1});
    x    = dif - ds;
    // divide toward zero
    xs   = x + (x[35] ? 36'sd7 : 36'sd0);
    xq   = xs >>> 3;
    sd   = ds + xq;
    if (sd < lo) sd = lo;
    if (sd > hi) sd = hi;
    sp = limit_steps_on_r ? sd : dif;
    if (sp < 36'sd1) sp = 36'sd1;
    span2_nxt = sp[32:0];
  end

  logic          v2_r;
  logic [32:0]   span2_r;
  dsr_pkg::dec_t dec2_r;
  logic          byp2_r;
  logic [31:0]   bval2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      span2_r <= span2_nxt;
      dec2_r  <= dec1_r;
      byp2_r  <= byp1_r;
      bval2_r <= bval1_r;
    end
  end

  // stage 3: mantissa times span
  logic [55:0] m3_nxt;
  always_comb begin
    if (dec2_r.zero) m3_nxt = '0;
    else if (dec2_r.sat) m3_nxt = 56'(span2_r);
    else m3_nxt = 56'({33'b0, dec2_r.mant}) * 56'(span2_r);
  end

  logic                     v3_r;
  logic [55:0]              m3_r;
  logic                     sat3_r;
  logic [dsr_pkg::SH_W-1:0] sh3_r;
  logic                     byp3_r;
  logic [31:0]              bval3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_r    <= m3_nxt;
      sat3_r  <= dec2_r.sat;
      sh3_r   <= dec2_r.sh;
      byp3_r  <= byp2_r;
      bval3_r <= bval2_r;
    end
  end

  // stage 4: align dividend so the quotient keeps 64 or 65 significant bits, unless the target's shift is smaller
  logic [6:0]               lm, ld;
  logic [7:0]               kc;
  logic [dsr_pkg::SH_W-1:0] kk;
  logic [dsr_pkg::D_W-1:0]  d4_nxt;
  dsr_pkg::sb_t             sb4_nxt;

  always_comb begin
    lm = dsr_pkg::len65(dsr_pkg::Q_W'(m3_r));
    ld = dsr_pkg::len65(dsr_pkg::Q_W'(deff));
    kc = 8'd64 - {1'b0, lm} + {1'b0, ld};
    kk = ({1'b0, kc} < sh3_r) ? {1'b0, kc} : sh3_r;
    // a saturated target is all ones, one below span << k
    d4_nxt = (dsr_pkg::D_W'({40'b0, m3_r}) << kk[6:0]) - dsr_pkg::D_W'(sat3_r);
    sb4_nxt.byp     = byp3_r;
    sb4_nxt.byp_val = bval3_r;
    sb4_nxt.j       = sh3_r - kk;
  end

  logic                    v4_r;
  logic [dsr_pkg::D_W-1:0] d4_r;
  dsr_pkg::sb_t            sb4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d4_r  <= d4_nxt;
      sb4_r <= sb4_nxt;
    end
  end

  logic                    vq;
  logic [dsr_pkg::Q_W-1:0] qq;
  dsr_pkg::sb_t            sbq;

  dsr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v4_r),
    .in_d    (d4_r),
    .in_sb   (sb4_r),
    .divisor (deff),
    .out_v   (vq),
    .out_q   (qq),
    .out_sb  (sbq)
  );

  // stage 5: normalize quotient and limit to a top-aligned window plus bit length
  logic [6:0]              lq, ll;
  logic [dsr_pkg::Q_W-1:0] wq5_nxt, wl5_nxt;
  logic [9:0]              nq5_nxt, nl5_nxt;
  dsr_pkg::dec_t           decl;

  always_comb begin
    lq      = dsr_pkg::len65(qq);
    wq5_nxt = qq << (7'(dsr_pkg::Q_W) - lq);
    nq5_nxt = (lq == '0) ? '0 : {3'b000, lq} + {1'b0, sbq.j};
    decl    = dsr_pkg::decode(target_limit_r);
    ll      = dsr_pkg::len65(dsr_pkg::Q_W'(decl.mant));
    if (decl.zero) begin
      wl5_nxt = '0;
      nl5_nxt = '0;
    end else if (decl.sat) begin
      wl5_nxt = '1;
      nl5_nxt = 10'(dsr_pkg::TARGET_BITS);
    end else begin
      wl5_nxt = dsr_pkg::Q_W'(decl.mant) << (7'(dsr_pkg::Q_W) - ll);
      nl5_nxt = {3'b000, ll} + {1'b0, decl.sh};
    end
  end

  logic                    v5_r;
  logic [dsr_pkg::Q_W-1:0] wq5_r, wl5_r;
  logic [9:0]              nq5_r, nl5_r;
  logic                    byp5_r;
  logic [31:0]             bval5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= vq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wq5_r   <= wq5_nxt;
      wl5_r   <= wl5_nxt;
      nq5_r   <= nq5_nxt;
      nl5_r   <= nl5_nxt;
      byp5_r  <= sbq.byp;
      bval5_r <= sbq.byp_val;
    end
  end

  // stage 6: cap at the limit and encode
  logic                    cap;
  logic [dsr_pkg::Q_W-1:0] wr, cw;
  logic [9:0]              nr, sz, tt;
  logic [23:0]             cmp;
  logic [7:0]              sz8;
  logic [31:0]             enc;

  always_comb begin
    cap = (nq5_r > nl5_r) || ((nq5_r == nl5_r) && (wq5_r > wl5_r));
    wr  = cap ? wl5_r : wq5_r;
    nr  = cap ? nl5_r : nq5_r;
    sz  = (nr + 10'd7) >> 3;
    // mantissa width taken from the top of the window
    tt  = nr + 10'd24 - {sz[6:0], 3'b000};
    cw  = wr >> (7'(dsr_pkg::Q_W) - {2'b00, tt[4:0]});
    cmp = cw[23:0];
    sz8 = sz[7:0];
    if (cmp[23]) begin
      cmp = cmp >> 8;
      sz8 = sz8 + 8'd1;
    end
    enc = byp5_r ? bval5_r : {sz8, cmp};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_next_bits_r <= enc;
      out_byp_r       <= byp5_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_next_bits = out_next_bits_r;

  a_span_pos: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (span2_r != '0))
    else $error("span reached zero");

  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> ({1'b0, d4_r[dsr_pkg::D_W-1:dsr_pkg::Q_W]} < deff))
    else $error("dividend top exceeds divisor");

  a_enc_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_byp_r) |-> !out_next_bits_r[23])
    else $error("encoded target has sign bit set");

  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !in_valid) |=> !v1_r)
    else $error("item appeared without input");

endmodule

>>> test/digishield_target_retarget_test.sv
// testbench for the retarget block: directed table plus random items against a predictor
`timescale 1ns / 1ps

module digishield_target_retarget_test;

  localparam logic [1:0] HIST_BOTH = 2'd2;
  localparam logic [1:0] HIST_ODD  = 2'd3;
  localparam int         DRAIN_CYCLES = 80;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [1:0]  hist;
    logic [31:0] last_time;
    logic [31:0] prev_time;
    logic [31:0] last_bits;
    logic        known;
    logic [31:0] next_bits;
  } retarget_row_t;

  localparam int NDIR = 22;
  localparam retarget_row_t DIRECTED[NDIR] = '{
    '{dsr_pkg::HIST_NONE, 32'd0, 32'd0, 32'd0, 1'b1, 32'h1e0fffff},
    '{dsr_pkg::HIST_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1, 32'h1e0fffff},
    '{dsr_pkg::HIST_LAST, 32'd0, 32'd0, 32'hffffffff, 1'b1, 32'hffffffff},
    '{dsr_pkg::HIST_LAST, 32'd1234, 32'd0, 32'd0, 1'b1, 32'd0},
    '{HIST_BOTH, 32'd1000, 32'd940, 32'h1d00ffff, 1'b0, 32'd0},
    '{HIST_BOTH, 32'd1000, 32'd1000, 32'h1d00ffff, 1'b0, 32'd0},
    '{HIST_BOTH, 32'd0, 32'hffffffff, 32'h1d00ffff, 1'b0, 32'd0},
    '{HIST_BOTH, 32'hffffffff, 32'd0, 32'h1d00ffff, 1'b0, 32'd0},
    '{HIST_BOTH, 32'd100, 32'd40, 32'h1d80ffff, 1'b1, 32'd0},
    '{HIST_BOTH, 32'd100, 32'd40, 32'hff7fffff, 1'b1, 32'h1e0fffff},
    '{HIST_BOTH, 32'd100, 32'd40, 32'd0, 1'b1, 32'd0},
    '{HIST_BOTH, 32'd100, 32'd40, 32'h1e0fffff, 1'b1, 32'h1e0fffff},
    '{HIST_ODD, 32'd100, 32'd40, 32'h1c00ffff, 1'b0, 32'd0},
    '{HIST_BOTH, 32'd500, 32'd400, 32'h00123456, 1'b0, 32'd0},
    '{HIST_BOTH, 32'd500, 32'd400, 32'h01123456, 1'b0, 32'd0},
    '{HIST_BOTH, 32'd500, 32'd400, 32'h02123456, 1'b0, 32'd0},
    '{HIST_BOTH, 32'd500, 32'd400, 32'h03123456, 1'b0, 32'd0},
    '{HIST_BOTH, 32'd500, 32'd450, 32'h03800000, 1'b1, 32'd0},
    '{HIST_BOTH, 32'd500, 32'd450, 32'h047fffff, 1'b0, 32'd0},
    '{HIST_BOTH, 32'hffffffff, 32'hfffffff0, 32'h1b0404cb, 1'b0, 32'd0},
    '{HIST_BOTH, 32'd7, 32'd8, 32'h207fffff, 1'b0, 32'd0},
    '{HIST_ODD, 32'd60, 32'd0, 32'h1e0fffff, 1'b0, 32'd0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_history;
  logic [31:0] in_last_time;
  logic [31:0] in_prev_time;
  logic [31:0] in_last_bits;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_next_bits;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  // shadow copy of the registers
  logic [31:0] desired_m;
  logic [31:0] limit_m;
  logic        steps_m;

  logic [31:0] pending_bits[$];
  int          errors;
  int          results_seen;
  int          cycles;
  bit          hold_req;
  bit          eager;

  digishield_target_retarget u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_history   (in_history),
    .in_last_time (in_last_time),
    .in_prev_time (in_prev_time),
    .in_last_bits (in_last_bits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_next_bits(out_next_bits),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [319:0] unpack_target(input logic [31:0] w);
    logic [319:0] v;
    logic [31:0]  m;
    int           sz;
    int           p;
    v  = '0;
    sz = int'(w[31:24]);
    m  = {9'b0, w[22:0]};
    if (w[23]) return '0;
    if (sz <= 3) begin
      m = m >> (8 * (3 - sz));
      return 320'(m);
    end
    for (int i = 0; i < 23; i++) begin
      if (m[i]) begin
        p = i + 8 * (sz - 3);
        // past the top bit the value pins to all ones
        if (p >= dsr_pkg::TARGET_BITS) return {64'b0, {256{1'b1}}};
        v[p] = 1'b1;
      end
    end
    return v;
  endfunction

  function automatic logic [31:0] pack_target(input logic [319:0] v);
    int          nbits;
    int          sz;
    logic [31:0] compact;
    nbits = 0;
    for (int i = 0; i < 320; i++) begin
      if (v[i]) nbits = i + 1;
    end
    sz = (nbits + 7) / 8;
    if (sz <= 3) compact = {8'b0, v[23:0]} << (8 * (3 - sz));
    else compact = {8'b0, 24'(v >> (8 * (sz - 3)))};
    if (compact[23]) begin
      compact = compact >> 8;
      sz++;
    end
    return {8'(sz), compact[23:0]};
  endfunction

  function automatic logic [31:0] next_target(input logic [1:0] hist, input logic [31:0] lt,
                                              input logic [31:0] pt, input logic [31:0] lb);
    longint       d;
    longint       sp;
    longint       lo;
    longint       hi;
    logic [319:0] v;
    logic [319:0] lim;
    if (hist == dsr_pkg::HIST_NONE) return limit_m;
    if (hist == dsr_pkg::HIST_LAST) return lb;
    d  = (desired_m == 0) ? 64'sd1 : longint'({32'b0, desired_m});
    sp = longint'({32'b0, lt}) - longint'({32'b0, pt});
    if (steps_m) begin
      lo = (d * 3) / 4;
      hi = (d * 3) / 2;
      sp = d + (sp - d) / 8;
      if (sp < lo) sp = lo;
      if (sp > hi) sp = hi;
    end
    if (sp < 1) sp = 1;
    v   = unpack_target(lb);
    v   = v * 320'(sp);
    v   = v / 320'(d);
    lim = unpack_target(limit_m);
    if (v > lim) v = lim;
    return pack_target(v);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (eager || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dsr_pkg::CFG_DESIRED: desired_m = val;
      dsr_pkg::CFG_LIMIT:   limit_m = val;
      default:              steps_m = val[0];
    endcase
  endtask

  // offer one item, hold it until taken, record what should come back
  task automatic send_item(input logic [1:0] hist, input logic [31:0] lt, input logic [31:0] pt,
                           input logic [31:0] lb, input bit known, input logic [31:0] nb);
    int g;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_history   <= hist;
    in_last_time <= lt;
    in_prev_time <= pt;
    in_last_bits <= lb;
    do @(posedge clk); while (!in_ready);
    if (known && nb !== next_target(hist, lt, pt, lb)) begin
      $display("%0t: table entry disagrees with predictor: expected %h, predicted %h",
               $time, nb, next_target(hist, lt, pt, lb));
      errors++;
    end
    pending_bits.push_back(known ? nb : next_target(hist, lt, pt, lb));
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_items(input int n);
    logic [1:0]  hist;
    logic [31:0] pt;
    logic [31:0] lt;
    logic [31:0] lb;
    int          r;
    for (int k = 0; k < n; k++) begin
      r    = $urandom_range(0, 99);
      hist = (r < 8) ? dsr_pkg::HIST_NONE : (r < 16) ? dsr_pkg::HIST_LAST :
             (r < 20) ? HIST_ODD : HIST_BOTH;
      pt   = $urandom;
      r    = $urandom_range(0, 99);
      // mostly plausible block spacing around the desired span
      if (r < 75) lt = pt + 32'($urandom_range(0, 4 * (desired_m % 5000) + 20)) - 32'd10;
      else lt = $urandom;
      r = $urandom_range(0, 99);
      if (r < 70) lb = {8'($urandom_range(0, 34)), 1'b0, 23'($urandom)};
      else lb = $urandom;
      send_item(hist, lt, pt, lb, 1'b0, 32'd0);
      if (k == n / 3) hold_req = 1'b1;
    end
  endtask

  // receiver: random stalls and short hold-offs, and a long hold-off on each request
  initial begin
    int hold_left;
    int r;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (eager) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 97) out_ready <= (r < 70);
        else begin
          out_ready <= 1'b0;
          hold_left = $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_bits.size() == 0) begin
        $display("%0t: unexpected result: actual next_bits %h", $time, out_next_bits);
        errors++;
      end else if (out_next_bits !== pending_bits[0]) begin
        $display("%0t: next_bits mismatch: expected %h, actual %h",
                 $time, pending_bits[0], out_next_bits);
        errors++;
        void'(pending_bits.pop_front());
      end else begin
        void'(pending_bits.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_bits.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    errors       = 0;
    results_seen = 0;
    cycles       = 0;
    hold_req     = 1'b0;
    eager        = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_history   = dsr_pkg::HIST_NONE;
    in_last_time = '0;
    in_prev_time = '0;
    in_last_bits = '0;
    cfg_we       = 1'b0;
    cfg_index    = dsr_pkg::CFG_DESIRED;
    cfg_wdata    = '0;
    desired_m    = 32'd60;
    limit_m      = 32'h1e0fffff;
    steps_m      = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NDIR; i++) begin
      send_item(DIRECTED[i].hist, DIRECTED[i].last_time, DIRECTED[i].prev_time,
                DIRECTED[i].last_bits, DIRECTED[i].known, DIRECTED[i].next_bits);
    end
    drain();

    random_items(200);
    drain();

    // smallest desired span, steps off, top limit
    write_reg(dsr_pkg::CFG_DESIRED, 32'd1);
    write_reg(dsr_pkg::CFG_LIMIT, 32'h207fffff);
    write_reg(dsr_pkg::CFG_STEPS, 1'b0);
    eager = 1'b1;
    random_items(150);
    drain();
    eager = 1'b0;

    write_reg(dsr_pkg::CFG_DESIRED, 32'hffffffff);
    write_reg(dsr_pkg::CFG_LIMIT, 32'h1d00ffff);
    write_reg(dsr_pkg::CFG_STEPS, 1'b1);
    random_items(150);
    drain();

    // zero desired span and a negative limit word
    write_reg(dsr_pkg::CFG_DESIRED, 32'd0);
    write_reg(dsr_pkg::CFG_LIMIT, 32'hffffffff);
    write_reg(dsr_pkg::CFG_STEPS, 1'b0);
    random_items(100);
    drain();

    write_reg(dsr_pkg::CFG_DESIRED, 32'd600);
    write_reg(dsr_pkg::CFG_LIMIT, 32'h00000000);
    random_items(80);
    drain();

    write_reg(dsr_pkg::CFG_DESIRED, 32'd150);
    write_reg(dsr_pkg::CFG_LIMIT, 32'h2100ffff);
    write_reg(dsr_pkg::CFG_STEPS, 1'b1);
    random_items(200);
    drain();

    $display("ran %0d directed and about 880 random items over six register settings",
             NDIR);
    $display("checked %0d results, %0d mismatches", results_seen, errors);
    if (errors == 0 && pending_bits.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
